// File: hw/rtl/abr_pkg.sv
// Shared types and constants for the alternate block reverser.
package abr_pkg;

   // Fixed field widths
   localparam int ELEM_W = 16;
   localparam int CSR_W = 7;

   // Default largest block the store can hold
   localparam int MAX_BLOCK_DEF = 64;

   typedef struct packed {
      logic [ELEM_W-1:0] element_value;
      logic              sequence_end;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] out_value;
      logic              out_sequence_end;
      logic              run_last;
   } rsp_type;

endpackage

// File: hw/rtl/abr_store.sv
// Block store: one write port, one registered read port with enable.
module abr_store #(
   parameter int DEPTH = abr_pkg::MAX_BLOCK_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [abr_pkg::ELEM_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [abr_pkg::ELEM_W-1:0] rd_data
);
   import abr_pkg::*;

   logic [ELEM_W-1:0] store_mem_ff [DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while the consumer is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/abr_ctrl.sv
// Block sequencer: fill/phase tracking, drain sequencing and output stage.
module abr_ctrl #(
   parameter int MAX_BLOCK = abr_pkg::MAX_BLOCK_DEF,
   localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
   localparam int FW = $clog2(MAX_BLOCK + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [abr_pkg::CSR_W-1:0]  csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  abr_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output abr_pkg::rsp_type           rsp_payload,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic [abr_pkg::ELEM_W-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  logic [abr_pkg::ELEM_W-1:0] mem_rd_data
);
   import abr_pkg::*;

   // Control state
   logic [CSR_W-1:0]  size_ff, size_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              phase_ff, phase_in;
   logic              drain_ff, drain_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              end_ff, end_in;

   // Output stage
   logic              valid_ff, valid_in;
   logic              src_mem_ff, src_mem_in;
   logic [ELEM_W-1:0] bypass_ff, bypass_in;
   logic              oend_ff, oend_in;
   logic              olast_ff, olast_in;

   logic              adv;
   logic              take;
   logic [FW-1:0]     size_eff;
   logic [FW-1:0]     fill_inc;
   logic              full;

   // Output stage can load when empty or being taken
   assign adv = !valid_ff || !rsp_stall;
   assign req_stall = drain_ff || !adv;
   assign take = req_valid && !req_stall;

   // Clamp block size to 1..MAX_BLOCK
   always_comb begin
      if (size_ff == '0) begin
         size_eff = FW'(1);
      end else if (32'(size_ff) > MAX_BLOCK) begin
         size_eff = FW'(MAX_BLOCK);
      end else begin
         size_eff = size_ff[FW-1:0];
      end
   end

   assign fill_inc = fill_ff + FW'(1);
   assign full = fill_inc >= size_eff;

   // Store write on every reversed element
   assign mem_wr_en = take && phase_ff;
   assign mem_wr_addr = fill_ff[AW-1:0];
   assign mem_wr_data = req_payload.element_value;

   // Store read while draining
   assign mem_rd_en = drain_ff && adv;
   assign mem_rd_addr = rd_idx_ff;

   // Next-state logic
   always_comb begin
      size_in = csr_wr_en ? csr_wr_data : size_ff;
      fill_in = fill_ff;
      phase_in = phase_ff;
      drain_in = drain_ff;
      rd_idx_in = rd_idx_ff;
      end_in = end_ff;
      valid_in = valid_ff;
      src_mem_in = src_mem_ff;
      bypass_in = bypass_ff;
      oend_in = oend_ff;
      olast_in = olast_ff;

      if (adv) begin
         valid_in = 1'b0;
      end

      if (drain_ff && adv) begin
         // Older entries come out of the store, newest first
         valid_in = 1'b1;
         src_mem_in = 1'b1;
         oend_in = end_ff && (rd_idx_ff == '0);
         olast_in = (rd_idx_ff == '0);
         if (rd_idx_ff == '0) begin
            drain_in = 1'b0;
         end else begin
            rd_idx_in = rd_idx_ff - AW'(1);
         end
      end else if (take) begin
         if (phase_ff) begin
            if (full || req_payload.sequence_end) begin
               // Block closes: newest element leaves straight from the input
               valid_in = 1'b1;
               src_mem_in = 1'b0;
               bypass_in = req_payload.element_value;
               oend_in = req_payload.sequence_end && (fill_ff == '0);
               olast_in = (fill_ff == '0);
               if (fill_ff != '0) begin
                  drain_in = 1'b1;
                  rd_idx_in = fill_ff[AW-1:0] - AW'(1);
                  end_in = req_payload.sequence_end;
               end
               fill_in = '0;
               phase_in = 1'b0;
            end else begin
               fill_in = fill_inc;
            end
         end else begin
            // Straight block: pass through
            valid_in = 1'b1;
            src_mem_in = 1'b0;
            bypass_in = req_payload.element_value;
            oend_in = req_payload.sequence_end;
            olast_in = 1'b1;
            if (full) begin
               fill_in = '0;
               phase_in = 1'b1;
            end else begin
               fill_in = fill_inc;
            end
         end
         if (req_payload.sequence_end) begin
            fill_in = '0;
            phase_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CSR_W'(1);
         fill_ff <= '0;
         phase_ff <= 1'b1;
         drain_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         size_ff <= size_in;
         fill_ff <= fill_in;
         phase_ff <= phase_in;
         drain_ff <= drain_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      end_ff <= end_in;
      src_mem_ff <= src_mem_in;
      bypass_ff <= bypass_in;
      oend_ff <= oend_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_payload.out_value = src_mem_ff ? mem_rd_data : bypass_ff;
   assign rsp_payload.out_sequence_end = oend_ff;
   assign rsp_payload.run_last = olast_ff;

endmodule

// File: hw/rtl/alternate_block_reverser_top.sv
// Top level of the alternate block reverser.
//
//  port group | dir | handshake          | contents
//  req_*      | in  | req_valid/stall    | element value, end-of-sequence flag
//  rsp_*      | out | rsp_valid/stall    | reordered value, end flag, run-last flag
//  csr_*      | in  | csr_wr_en          | block size (7 bits)
//
// Straight and non-closing reversed elements enter without req_stall unless
// rsp_stall backs up the output. A reversed block of n elements registers its
// newest element from the input as it closes, then holds req_stall while the
// other n-1 come out of the single store read port one per cycle unless stalled.
// Synchronous reset clears control state only; the store is not cleared.
// rsp_stall freezes the output register and the store read register.
module alternate_block_reverser_top #(
   parameter int MAX_BLOCK = abr_pkg::MAX_BLOCK_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [abr_pkg::CSR_W-1:0] csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  abr_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output abr_pkg::rsp_type          rsp_payload
);
   import abr_pkg::*;

   localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [ELEM_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [ELEM_W-1:0] mem_rd_data;

   abr_ctrl #(
      .MAX_BLOCK(MAX_BLOCK)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   abr_store #(
      .DEPTH(MAX_BLOCK)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// File: hw/rtl/abr_checker.sv
// Port-level checks for the alternate block reverser, bound to the top level.
module abr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input abr_pkg::rsp_type          rsp_payload
);
   import abr_pkg::*;

   // Nothing to send right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Sequence end only closes a run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_sequence_end |-> rsp_payload.run_last)
      else $error("sequence end without run_last");

   // Input held off while a reversed run is still draining
   a_drain_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.run_last |-> req_stall)
      else $error("input open during drain");

   // A run that is not finished keeps producing
   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.run_last |=> rsp_valid)
      else $error("run broken before run_last");

endmodule

bind alternate_block_reverser_top abr_checker u_abr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
